>>> design/strm_pkg.sv
// Shared types and constants for the sparse table range maximum unit.
// No dependencies; used by strm_table and sparse_table_range_max_unit.
package strm_pkg;

    // Table geometry and data width.
    localparam int MAX_ENTRIES = 1024;
    localparam int LEVELS      = 11;
    localparam int VALUE_WIDTH = 32;

    // Derived widths.
    localparam int IDX_W     = $clog2(MAX_ENTRIES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int TBL_DEPTH = LEVELS * MAX_ENTRIES;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    // Configuration port.
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

    // Command codes.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Access request to the window table: one write port, two read ports.
    typedef struct packed {
        logic                   wr_en;
        logic [TBL_AW-1:0]      wr_addr;
        logic [VALUE_WIDTH-1:0] wr_data;
        logic [TBL_AW-1:0]      rd_addr_a;
        logic [TBL_AW-1:0]      rd_addr_b;
    } t_tbl_req;

endpackage

>>> design/strm_table.sv
// Window table memory with two registered read ports and the shared max unit.
// Depends on strm_pkg for geometry and the request struct.
module strm_table (
    input  logic                                   i_clk,
    input  strm_pkg::t_tbl_req                     i_req,
    output logic signed [strm_pkg::VALUE_WIDTH-1:0] o_max
);

    logic [strm_pkg::VALUE_WIDTH-1:0] m_tbl [strm_pkg::TBL_DEPTH];
    logic signed [strm_pkg::VALUE_WIDTH-1:0] r_rd_a;
    logic signed [strm_pkg::VALUE_WIDTH-1:0] r_rd_b;

    // One write and two reads per cycle; read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            m_tbl[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_a <= $signed(m_tbl[i_req.rd_addr_a]);
        r_rd_b <= $signed(m_tbl[i_req.rd_addr_b]);
    end

    // Shared signed compare: serves both the build passes and the queries.
    assign o_max = (r_rd_a > r_rd_b) ? r_rd_a : r_rd_b;

endmodule

>>> design/sparse_table_range_max_unit.sv
// Top level of the sparse table range maximum unit: sequencer, value store,
// config register and output register. Depends on strm_pkg and strm_table.
//
// Usage: items arrive on the input channel (i_in_valid / o_in_ready) with a
// command, and queries return one result beat on the output channel
// (o_out_valid / i_out_ready). A load writes a value into the store. A build
// walks each level of the table whose window fits in the first
// min(count_in_use, 1024) values, one table entry at a time (read, then
// compare and write), through the single write port of the table. For a
// query, the range is registered when the query is accepted, both windows
// are then read from the table into its registered read ports, and the
// compare of the two puts their maximum into the output register. The input
// is not ready again until the query's result enters the output register.
// Loads and builds are accepted while a result still waits in the output
// register; a query that finishes while the receiver stalls holds in its
// compare step until the register is free. Reset (synchronous, active low)
// returns the sequencer to idle, drops any pending result and sets
// count_in_use to 1024; the value store and the table are undefined until
// loaded and built. count_in_use is to be written over the APB port at byte
// address 0 only while the unit is idle; the unit does not enforce this.
module sparse_table_range_max_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Input channel.
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [1:0]                              i_cmd,
    input  logic [strm_pkg::IDX_W-1:0]              i_index,
    input  logic signed [strm_pkg::VALUE_WIDTH-1:0] i_value,
    input  logic [strm_pkg::IDX_W-1:0]              i_left,
    input  logic [strm_pkg::IDX_W-1:0]              i_right,
    // Output channel.
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [strm_pkg::VALUE_WIDTH-1:0] o_max_value,
    output logic [1:0]                              o_status,
    // Configuration port.
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [strm_pkg::PADDR_W-1:0]            paddr,
    input  logic [strm_pkg::PDATA_W-1:0]            pwdata,
    output logic [strm_pkg::PDATA_W-1:0]            prdata,
    output logic                                    pready
);

    localparam int IDX_W = strm_pkg::IDX_W;
    localparam int CNT_W = strm_pkg::CNT_W;
    localparam int LVL_W = strm_pkg::LVL_W;
    localparam int VW    = strm_pkg::VALUE_WIDTH;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_B_RD  = 3'd1;
    localparam logic [2:0] S_B_WR  = 3'd2;
    localparam logic [2:0] S_Q_RD  = 3'd3;
    localparam logic [2:0] S_Q_CMP = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [LVL_W-1:0]       r_lv, n_lv;
    logic [CNT_W-1:0]       r_j, n_j;
    logic [IDX_W-1:0]       r_left, n_left;
    logic [IDX_W-1:0]       r_right, n_right;
    logic [1:0]             r_qstat, n_qstat;
    logic [CNT_W-1:0]       r_count;
    logic                   r_out_valid, n_out_valid;
    logic signed [VW-1:0]   r_out_max, n_out_max;
    logic [1:0]             r_out_status, n_out_status;

    logic [VW-1:0]          m_base [strm_pkg::MAX_ENTRIES];
    logic signed [VW-1:0]   r_base_rd;

    logic                   in_beat;
    logic                   out_free;
    logic [CNT_W-1:0]       n_eff;
    logic [CNT_W-1:0]       win;
    logic [CNT_W-1:0]       half;
    logic [LVL_W-1:0]       lv_prev;
    logic [CNT_W:0]         next_end;
    logic [CNT_W+1:0]       next_win;
    logic                   lv_last;
    logic [CNT_W-1:0]       q_len;
    logic [LVL_W-1:0]       q_k;
    logic [CNT_W-1:0]       q_b_start;
    logic signed [VW-1:0]   tbl_max;
    strm_pkg::t_tbl_req     tbl_req;

    // Effective count is capped at the store size.
    assign n_eff = (r_count > CNT_W'(strm_pkg::MAX_ENTRIES))
                 ? CNT_W'(strm_pkg::MAX_ENTRIES) : r_count;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_beat    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Build geometry for the current level.
    assign win      = CNT_W'(1) << r_lv;
    assign lv_prev  = (r_lv == '0) ? '0 : r_lv - LVL_W'(1);
    assign half     = (r_lv == '0) ? '0 : (CNT_W'(1) << lv_prev);
    assign next_end = {1'b0, r_j} + (CNT_W+1)'(1) + {1'b0, win};
    assign next_win = (CNT_W+2)'(2) << r_lv;
    assign lv_last  = (32'(r_lv) + 1 >= strm_pkg::LEVELS)
                   || (next_win > (CNT_W+2)'(n_eff));

    // Query geometry: largest power of two not above the range length.
    assign q_len = CNT_W'(r_right) - CNT_W'(r_left) + CNT_W'(1);
    always_comb begin
        q_k = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (q_len[i] && (i < strm_pkg::LEVELS)) begin
                q_k = LVL_W'(i);
            end
        end
    end
    assign q_b_start = CNT_W'(r_right) + CNT_W'(1) - (CNT_W'(1) << q_k);

    // Table port: build addresses during a build, query addresses otherwise.
    always_comb begin
        tbl_req.wr_en   = (r_state == S_B_WR);
        tbl_req.wr_addr = {r_lv, r_j[IDX_W-1:0]};
        tbl_req.wr_data = (r_lv == '0) ? r_base_rd : tbl_max;
        if ((r_state == S_B_RD) || (r_state == S_B_WR)) begin
            tbl_req.rd_addr_a = {lv_prev, r_j[IDX_W-1:0]};
            tbl_req.rd_addr_b = {lv_prev, r_j[IDX_W-1:0] + half[IDX_W-1:0]};
        end else begin
            tbl_req.rd_addr_a = {q_k, r_left};
            tbl_req.rd_addr_b = {q_k, q_b_start[IDX_W-1:0]};
        end
    end

    strm_table u_table (
        .i_clk (i_clk),
        .i_req (tbl_req),
        .o_max (tbl_max)
    );

    // Value store: written by loads, read one entry at a time by level zero.
    always_ff @(posedge i_clk) begin
        if (in_beat && (i_cmd == strm_pkg::CMD_LOAD)) begin
            m_base[i_index] <= i_value;
        end
        r_base_rd <= $signed(m_base[r_j[IDX_W-1:0]]);
    end

    // Sequencer and output register next-state logic.
    always_comb begin
        n_state      = r_state;
        n_lv         = r_lv;
        n_j          = r_j;
        n_left       = r_left;
        n_right      = r_right;
        n_qstat      = r_qstat;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_max    = r_out_max;
        n_out_status = r_out_status;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    case (i_cmd)
                        strm_pkg::CMD_BUILD: begin
                            n_lv = '0;
                            n_j  = '0;
                            if (n_eff != '0) begin
                                n_state = S_B_RD;
                            end
                        end
                        strm_pkg::CMD_QUERY: begin
                            n_left  = i_left;
                            n_right = i_right;
                            if (i_left > i_right) begin
                                n_qstat = strm_pkg::ST_EMPTY;
                            end else if (CNT_W'(i_right) >= n_eff) begin
                                n_qstat = strm_pkg::ST_RANGE;
                            end else begin
                                n_qstat = strm_pkg::ST_OK;
                            end
                            n_state = S_Q_RD;
                        end
                        default: begin
                            // Loads finish in the store write; other codes do nothing.
                        end
                    endcase
                end
            end
            S_B_RD: begin
                n_state = S_B_WR;
            end
            S_B_WR: begin
                // Next entry of this level, the next level, or done.
                if (next_end <= (CNT_W+1)'(n_eff)) begin
                    n_j     = r_j + CNT_W'(1);
                    n_state = S_B_RD;
                end else if (!lv_last) begin
                    n_lv    = r_lv + LVL_W'(1);
                    n_j     = '0;
                    n_state = S_B_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_Q_RD: begin
                n_state = S_Q_CMP;
            end
            S_Q_CMP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_qstat;
                    n_out_max    = (r_qstat == strm_pkg::ST_OK) ? tbl_max : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lv        <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lv        <= n_lv;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_left       <= n_left;
        r_right      <= n_right;
        r_qstat      <= n_qstat;
        r_out_max    <= n_out_max;
        r_out_status <= n_out_status;
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= strm_pkg::COUNT_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == strm_pkg::REG_COUNT)) begin
            r_count <= pwdata[CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == strm_pkg::REG_COUNT)
                  ? strm_pkg::PDATA_W'(r_count) : '0;

    assign o_out_valid = r_out_valid;
    assign o_max_value = r_out_max;
    assign o_status    = r_out_status;

    // A table write always covers a window that ends within the effective count.
    a_build_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B_WR) |-> (({1'b0, r_j} + {1'b0, win}) <= (CNT_W+1)'(n_eff)))
        else $error("build writes beyond the effective count");

    // The build never goes past the last level.
    a_build_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B_RD) |-> (32'(r_lv) < strm_pkg::LEVELS))
        else $error("build level out of range");

    // A result that is not ok always carries a zero maximum.
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != strm_pkg::ST_OK)) |-> (o_max_value == '0))
        else $error("nonzero maximum on an error status");

    // A new result is loaded only when the previous one has left.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_CMP && r_out_valid && !i_out_ready) |=> (r_state == S_Q_CMP))
        else $error("query left compare step while output was stalled");

    // An ok query has its whole range below the effective count.
    a_query_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_CMP && r_qstat == strm_pkg::ST_OK)
            |-> (r_left <= r_right && CNT_W'(r_right) < n_eff))
        else $error("ok status on an invalid range");

endmodule
